@@ hw/rtl/rth_pkg.sv @@
`default_nettype none

package rth_pkg;

  // Channel that holds the maximum; selects the hue sector.
  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } rth_sector_t;

endpackage : rth_pkg

`default_nettype wire

@@ hw/rtl/rgb_to_hsv_convert_core.sv @@
`default_nettype none

// Channel  | Dir | Ports                        | Payload
// ---------+-----+------------------------------+--------------------------------
// pixel in | in  | in_tvalid/in_tready/in_tdata | red, green, blue
// hsv out  | out | out_tvalid/out_tready/out_tdata | hue, saturation, brightness
//
// One pixel per clock sustained while out_tready does not stall. The pipeline
// has two front stages plus 12 stages of the hue divider by default,
// set by the one-bit-per-stage restoring dividers.
// Reset clears only the valid bits; payload registers are not reset.
// A stall on out_tready freezes the whole pipeline in place; in_tready
// follows it, so no transfer is dropped or repeated.
module rgb_to_hsv_convert_core
  import rth_pkg::*;
#(
  parameter int CHANNEL_BITS = 8,
  parameter int HUE_BITS     = 12
) (
  input  wire logic clk,
  input  wire logic rst_n,

  input  wire logic in_tvalid,
  output logic      in_tready,
  // [C-1:0] red, [2C-1:C] green, [3C-1:2C] blue, zero pad to bytes
  input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0] in_tdata,

  output logic      out_tvalid,
  input  wire logic out_tready,
  // [H-1:0] hue, [H+C-1:H] saturation, [H+2C-1:H+C] brightness, zero pad
  output logic [((HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] out_tdata
);

  localparam int C     = CHANNEL_BITS;
  localparam int H     = HUE_BITS;
  localparam int OUT_W = ((H + 2*C + 7) / 8) * 8;
  localparam int DEPTH = (H > C) ? H : C;

  // Whole pipeline advances together.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // ---------------- stage 1: max, min, sector ----------------
  logic [C-1:0] red, green, blue;
  assign red   = in_tdata[C-1:0];
  assign green = in_tdata[2*C-1:C];
  assign blue  = in_tdata[3*C-1:2*C];

  logic        v1_r;
  logic [C-1:0] r1_r, g1_r, b1_r, mx1_r, mn1_r;
  rth_sector_t sec1_r;
  logic [C-1:0] mx1_nxt, mn1_nxt;
  rth_sector_t sec1_nxt;

  always_comb begin
    // ties: red first, then green
    if (red >= green && red >= blue) begin
      sec1_nxt = SEC_RED;
      mx1_nxt  = red;
    end else if (green >= blue) begin
      sec1_nxt = SEC_GREEN;
      mx1_nxt  = green;
    end else begin
      sec1_nxt = SEC_BLUE;
      mx1_nxt  = blue;
    end
    mn1_nxt = red;
    if (green < mn1_nxt) mn1_nxt = green;
    if (blue < mn1_nxt)  mn1_nxt = blue;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r   <= red;
      g1_r   <= green;
      b1_r   <= blue;
      mx1_r  <= mx1_nxt;
      mn1_r  <= mn1_nxt;
      sec1_r <= sec1_nxt;
    end
  end

  // ---------------- stage 2: delta, hue numerator, sat dividend ----------------
  logic [C-1:0]   delta;
  logic [C+2:0]   d3, r3, g3, b3, six_nxt, num_nxt;
  logic [2*C-1:0] sat_prod;

  always_comb begin
    delta = mx1_r - mn1_r;
    d3    = (C+3)'(delta);
    r3    = (C+3)'(r1_r);
    g3    = (C+3)'(g1_r);
    b3    = (C+3)'(b1_r);
    six_nxt = (d3 << 2) + (d3 << 1);
    // modular arithmetic: true result lies in [0, 6*delta)
    case (sec1_r)
      SEC_RED:   num_nxt = (g1_r >= b1_r) ? (g3 - b3) : (six_nxt + g3 - b3);
      SEC_GREEN: num_nxt = (d3 << 1) + b3 - r3;
      SEC_BLUE:  num_nxt = (d3 << 2) + r3 - g3;
      default:   num_nxt = '0;
    endcase
    // delta * (2^C - 1) without a multiplier
    sat_prod = {delta, {C{1'b0}}} - {{C{1'b0}}, delta};
  end

  logic           v2_r;
  logic [C+2:0]   num2_r, six2_r;
  logic [2*C-1:0] prod2_r;
  logic [C-1:0]   mx2_r;
  logic           hz2_r, sz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r  <= num_nxt;
      six2_r  <= six_nxt;
      prod2_r <= sat_prod;
      mx2_r   <= mx1_r;
      hz2_r   <= (delta == '0);
      sz2_r   <= (mx1_r == '0);
    end
  end

  // ---------------- divider stages ----------------
  logic [H-1:0] hue_q;
  logic [C-1:0] sat_q;

  // hue = num * 2^H / (6*delta); num below the divisor
  rth_div_pipe #(
    .RW    (C + 4),
    .STEPS (H),
    .DEPTH (DEPTH)
  ) u_hue_div (
    .clk    (clk),
    .en     (en),
    .rem_i  (num2_r),
    .div_i  (six2_r),
    .feed_i ({H{1'b0}}),
    .quo_o  (hue_q)
  );

  // saturation = delta*(2^C-1) / max; upper half is below max
  rth_div_pipe #(
    .RW    (C + 1),
    .STEPS (C),
    .DEPTH (DEPTH)
  ) u_sat_div (
    .clk    (clk),
    .en     (en),
    .rem_i  (prod2_r[2*C-1:C]),
    .div_i  (mx2_r),
    .feed_i (prod2_r[C-1:0]),
    .quo_o  (sat_q)
  );

  // side data delayed to line up with the divider outputs
  logic         vd_r [DEPTH];
  logic [C-1:0] mxd_r[DEPTH];
  logic         hzd_r[DEPTH];
  logic         szd_r[DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) vd_r[i] <= 1'b0;
    end else if (en) begin
      vd_r[0] <= v2_r;
      for (int i = 1; i < DEPTH; i++) vd_r[i] <= vd_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mxd_r[0] <= mx2_r;
      hzd_r[0] <= hz2_r;
      szd_r[0] <= sz2_r;
      for (int i = 1; i < DEPTH; i++) begin
        mxd_r[i] <= mxd_r[i-1];
        hzd_r[i] <= hzd_r[i-1];
        szd_r[i] <= szd_r[i-1];
      end
    end
  end

  // ---------------- output ----------------
  // gray pixel: zero divisor, force hue 0; black pixel: force saturation 0
  logic [H-1:0] hue;
  logic [C-1:0] saturation, brightness;

  assign hue        = hzd_r[DEPTH-1] ? '0 : hue_q;
  assign saturation = szd_r[DEPTH-1] ? '0 : sat_q;
  assign brightness = mxd_r[DEPTH-1];

  assign out_tvalid = vd_r[DEPTH-1];
  assign out_tdata  = OUT_W'({brightness, saturation, hue});

endmodule : rgb_to_hsv_convert_core

`default_nettype wire

@@ hw/rtl/rth_div_pipe.sv @@
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// rem_i must be below div_i; feed_i bits are shifted in MSB first.
// Stages past STEPS only carry the result along.
module rth_div_pipe #(
  parameter int RW    = 12,
  parameter int STEPS = 12,
  parameter int DEPTH = 12
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [RW-2:0]    rem_i,
  input  wire logic [RW-2:0]    div_i,
  input  wire logic [STEPS-1:0] feed_i,
  output logic      [STEPS-1:0] quo_o
);

  logic [RW-2:0]    rem_r  [DEPTH];
  logic [RW-2:0]    div_r  [DEPTH];
  logic [STEPS-1:0] feed_r [DEPTH];
  logic [STEPS-1:0] quo_r  [DEPTH];

  for (genvar s = 0; s < DEPTH; s++) begin : g_stage
    logic [RW-2:0]    rem_in;
    logic [RW-2:0]    div_in;
    logic [STEPS-1:0] feed_in;
    logic [STEPS-1:0] quo_in;
    logic [RW-2:0]    rem_nxt;
    logic [STEPS-1:0] feed_nxt;
    logic [STEPS-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign rem_in  = rem_i;
      assign div_in  = div_i;
      assign feed_in = feed_i;
      assign quo_in  = '0;
    end else begin : g_next
      assign rem_in  = rem_r[s-1];
      assign div_in  = div_r[s-1];
      assign feed_in = feed_r[s-1];
      assign quo_in  = quo_r[s-1];
    end

    if (s < STEPS) begin : g_step
      logic [RW-1:0] trial;
      logic [RW-1:0] diff;
      logic          fits;

      always_comb begin
        trial    = {rem_in, feed_in[STEPS-1]};
        diff     = trial - {1'b0, div_in};
        fits     = (trial >= {1'b0, div_in});
        rem_nxt  = fits ? diff[RW-2:0] : trial[RW-2:0];
        feed_nxt = {feed_in[STEPS-2:0], 1'b0};
        quo_nxt  = {quo_in[STEPS-2:0], fits};
      end
    end else begin : g_hold
      assign rem_nxt  = rem_in;
      assign feed_nxt = feed_in;
      assign quo_nxt  = quo_in;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= rem_nxt;
        div_r[s]  <= div_in;
        feed_r[s] <= feed_nxt;
        quo_r[s]  <= quo_nxt;
      end
    end
  end

  assign quo_o = quo_r[DEPTH-1];

endmodule : rth_div_pipe

`default_nettype wire
